// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge, reset included
`define GPB_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// property checked only while out of reset
`define GPB_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== design/gpb_pkg.sv =====
// ----------------------------------------------------------------------------
// gpb_pkg
// shared constants, types and helpers of the gradient palette builder
// ----------------------------------------------------------------------------
package gpb_pkg;

  // table geometry
  localparam int TABLE_SIZE = 256;
  localparam int TBL_AW     = $clog2(TABLE_SIZE);
  localparam int FILL_W     = $clog2(TABLE_SIZE + 1);

  // stop position and derived index
  localparam int POS_W   = 17;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = POS_W + $clog2(TABLE_SIZE + 1);
  localparam int IDX_W   = PROD_W - FRAC_W;
  localparam int SUM_W   = ((FILL_W > IDX_W) ? FILL_W : IDX_W) + 1;

  // colour and interpolation arithmetic
  localparam int BYTE_W   = 8;
  localparam int COLOUR_W = 3 * BYTE_W;
  localparam int QUO_W    = BYTE_W + FRAC_W;
  localparam int INC_W    = QUO_W + 1;
  localparam int ACC_W    = QUO_W + 2;
  localparam int CNT_W    = $clog2(QUO_W + 1);

  // channel counter
  localparam logic [1:0] CH_FIRST = 2'd0;
  localparam logic [1:0] CH_LAST  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_BEGIN  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FILL,
    ST_READ
  } state_t;

  typedef struct packed {
    logic                en;
    logic [TBL_AW-1:0]   addr;
    logic [COLOUR_W-1:0] data;
  } tbl_wr_t;

  function automatic logic [IDX_W-1:0] pos_to_index(input logic [POS_W-1:0] pos);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(pos) * PROD_W'(TABLE_SIZE);
    return prod[PROD_W-1:FRAC_W];
  endfunction

  function automatic logic [BYTE_W-1:0] chan_byte(input logic [COLOUR_W-1:0] colour,
                                                  input logic [1:0] ch);
    logic [BYTE_W-1:0] b;
    case (ch)
      2'd0:    b = colour[3*BYTE_W-1:2*BYTE_W];
      2'd1:    b = colour[2*BYTE_W-1:BYTE_W];
      default: b = colour[BYTE_W-1:0];
    endcase
    return b;
  endfunction

  // integer part of a signed q10.16 accumulator, clamped to a byte
  function automatic logic [BYTE_W-1:0] acc_to_byte(input logic signed [ACC_W-1:0] acc);
    logic [BYTE_W-1:0] b;
    if (acc[ACC_W-1]) begin
      b = '0;
    end else if (acc[ACC_W-2:QUO_W] != '0) begin
      b = '1;
    end else begin
      b = acc[QUO_W-1:FRAC_W];
    end
    return b;
  endfunction

endpackage

// ===== design/gpb_req_if.sv =====
// ----------------------------------------------------------------------------
// gpb_req_if
// request channel: one beat carries a stop or a read request
// ----------------------------------------------------------------------------
interface gpb_req_if;
  import gpb_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [POS_W-1:0]  position;
  logic [BYTE_W-1:0] red_in;
  logic [BYTE_W-1:0] green_in;
  logic [BYTE_W-1:0] blue_in;
  logic [7:0]        read_index;

  modport source (
    output valid, func, position, red_in, green_in, blue_in, read_index,
    input  ready
  );

  modport sink (
    input  valid, func, position, red_in, green_in, blue_in, read_index,
    output ready
  );

endinterface

// ===== design/gpb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gpb_rsp_if
// response channel: one beat carries a table entry
// ----------------------------------------------------------------------------
interface gpb_rsp_if;
  import gpb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red_out;
  logic [BYTE_W-1:0] green_out;
  logic [BYTE_W-1:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );

endinterface

// ===== design/gpb_divider.sv =====
// ----------------------------------------------------------------------------
// gpb_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gpb_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gpb_pkg::QUO_W-1:0]  dividend,
  input  logic [gpb_pkg::IDX_W-1:0]  divisor,
  output logic                       done,
  output logic [gpb_pkg::QUO_W-1:0]  quotient
);
  import gpb_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   rem;
  logic [QUO_W-1:0]   quo;
  logic [IDX_W:0]     shifted;
  logic [IDX_W+1:0]   trial;

  assign shifted  = {rem, quo[QUO_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!trial[IDX_W+1]) begin
        rem <= trial[IDX_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= shifted[IDX_W-1:0];
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/gpb_table.sv =====
// ----------------------------------------------------------------------------
// gpb_table
// colour table memory with per-entry valid bits, registered read
// ----------------------------------------------------------------------------
module gpb_table (
  input  logic                          clk,
  input  logic                          rst,
  input  gpb_pkg::tbl_wr_t              wr,
  input  logic                          rd_en,
  input  logic [gpb_pkg::TBL_AW-1:0]    rd_addr,
  output logic [gpb_pkg::COLOUR_W-1:0]  rd_data
);
  import gpb_pkg::*;

  logic [COLOUR_W-1:0] mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld;
  logic [COLOUR_W-1:0] rd_q;
  logic                rd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_hit <= vld[rd_addr];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  assign rd_data = rd_hit ? rd_q : '0;

endmodule

// ===== design/gradient_palette_builder_top.sv =====
// begin beat: taken while idle, ready again the next
// read beat: entry via table read register, then output register; ready again
//   as it shows on rsp; both wait while an earlier entry sits in the output register
// append beat: three divides on the shared divider, then the fill sweep writes steps + 1
//   entries, fewer at the table end
// reset: synchronous, clears control state and all table valid bits in the same cycle
// ----------------------------------------------------------------------------
// gradient_palette_builder_top
// builds a colour lookup table from gradient stops and serves entry reads
// ----------------------------------------------------------------------------
module gradient_palette_builder_top (
  input logic      clk,
  input logic      rst,
  gpb_req_if.sink   req,
  gpb_rsp_if.source rsp
);
  import gpb_pkg::*;

  // sequencer
  state_t state, state_next;

  // stop state
  logic [IDX_W-1:0]    prev_index;
  logic [COLOUR_W-1:0] prev_colour;
  logic [FILL_W-1:0]   fill_index;
  logic                have_start;

  // segment being built
  logic [IDX_W-1:0]    new_index;
  logic [COLOUR_W-1:0] new_colour;
  logic [IDX_W-1:0]    steps;
  logic [1:0]          ch;
  logic                dneg;
  logic signed [ACC_W-1:0] acc [3];
  logic signed [INC_W-1:0] inc [3];
  logic [FILL_W-1:0]   wr_idx;
  logic [IDX_W-1:0]    rem_steps;

  // read path and output register
  logic                rd_oob;
  logic                out_valid;
  logic [COLOUR_W-1:0] out_rgb;

  // handshake and control strobes
  logic accept;
  logic div_start;
  logic div_done;
  logic [QUO_W-1:0] div_quo;
  logic rd_en;
  tbl_wr_t tbl_wr;
  logic [COLOUR_W-1:0] tbl_rd_data;

  // combinational helpers
  logic [IDX_W-1:0]        pos_idx;
  logic signed [IDX_W:0]   step_diff;
  logic [IDX_W-1:0]        steps_c;
  logic [BYTE_W-1:0]       a_byte;
  logic [BYTE_W-1:0]       b_byte;
  logic signed [BYTE_W:0]  delta;
  logic [BYTE_W-1:0]       delta_mag;
  logic [QUO_W-1:0]        dividend;
  logic signed [INC_W-1:0] inc_c;
  logic                    fill_end;
  logic [SUM_W-1:0]        fill_sum;
  logic [FILL_W-1:0]       fill_sat;
  logic [TBL_AW+7:0]       ridx_ext;
  logic                    out_free;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  // index of the incoming stop and the segment length, at least one step
  assign pos_idx   = pos_to_index(req.position);
  assign step_diff = $signed({1'b0, pos_idx}) - $signed({1'b0, prev_index});
  assign steps_c   = (step_diff < $signed((IDX_W+1)'(1))) ? IDX_W'(1)
                                                          : step_diff[IDX_W-1:0];

  // per-channel divide operands: |b - a| << 16 over steps
  assign a_byte    = chan_byte(prev_colour, ch);
  assign b_byte    = chan_byte(new_colour, ch);
  assign delta     = $signed({1'b0, b_byte}) - $signed({1'b0, a_byte});
  assign delta_mag = delta[BYTE_W] ? BYTE_W'(-delta) : delta[BYTE_W-1:0];
  assign dividend  = {delta_mag, {FRAC_W{1'b0}}};
  // truncation toward zero: divide the magnitude, then restore the sign
  assign inc_c     = dneg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  // fill sweep ends after the last step or at the table end
  assign fill_end = (wr_idx >= FILL_W'(TABLE_SIZE)) || (rem_steps == '0);
  assign fill_sum = SUM_W'(fill_index) + SUM_W'(steps);
  assign fill_sat = (fill_sum > SUM_W'(TABLE_SIZE)) ? FILL_W'(TABLE_SIZE)
                                                    : fill_sum[FILL_W-1:0];

  // read indexes beyond the table return zero
  assign ridx_ext = (TBL_AW+8)'(req.read_index);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.func == FUNC_APPEND && have_start) begin
            state_next = ST_DIV_START;
          end else if (req.func == FUNC_READ) begin
            state_next = ST_READ;
          end
        end
      end
      ST_DIV_START: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (ch == CH_LAST) ? ST_FILL : ST_DIV_START;
        end
      end
      ST_FILL: begin
        if (fill_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready   = 1'b0;
    div_start   = 1'b0;
    rd_en       = 1'b0;
    tbl_wr.en   = 1'b0;
    tbl_wr.addr = wr_idx[TBL_AW-1:0];
    tbl_wr.data = {acc_to_byte(acc[0]), acc_to_byte(acc[1]), acc_to_byte(acc[2])};
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        rd_en     = req.valid && (req.func == FUNC_READ);
      end
      ST_DIV_START: begin
        div_start = 1'b1;
      end
      ST_FILL: begin
        tbl_wr.en = (wr_idx < FILL_W'(TABLE_SIZE));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stop state: set by begin beats, advanced at the end of each segment
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_index  <= '0;
      prev_colour <= '0;
      fill_index  <= '0;
      have_start  <= 1'b0;
    end else if (accept && req.func == FUNC_BEGIN) begin
      prev_index  <= pos_idx;
      prev_colour <= {req.red_in, req.green_in, req.blue_in};
      fill_index  <= '0;
      have_start  <= 1'b1;
    end else if (state == ST_FILL && fill_end) begin
      prev_index  <= new_index;
      prev_colour <= new_colour;
      fill_index  <= fill_sat;
    end
  end

  // segment datapath
  always_ff @(posedge clk) begin
    if (accept && req.func == FUNC_APPEND) begin
      new_index  <= pos_idx;
      new_colour <= {req.red_in, req.green_in, req.blue_in};
      steps      <= steps_c;
      rem_steps  <= steps_c;
      ch         <= CH_FIRST;
    end
    if (state == ST_IDLE) begin
      wr_idx <= fill_index;
    end
    if (state == ST_DIV_START) begin
      dneg <= delta[BYTE_W];
    end
    if (state == ST_DIV_WAIT && div_done) begin
      inc[ch] <= inc_c;
      acc[ch] <= $signed({2'b00, a_byte, {FRAC_W{1'b0}}});
      ch      <= ch + 2'd1;
    end
    if (state == ST_FILL) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= acc[i] + ACC_W'(inc[i]);
      end
      wr_idx <= wr_idx + FILL_W'(1);
      if (rem_steps != '0) begin
        rem_steps <= rem_steps - IDX_W'(1);
      end
    end
  end

  // out-of-range flag rides along with the table read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_oob <= (ridx_ext >= (TBL_AW+8)'(TABLE_SIZE));
    end
  end

  // output register: a finished entry waits here while new beats are taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_READ && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ && out_free) begin
      out_rgb <= rd_oob ? '0 : tbl_rd_data;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.red_out   = out_rgb[3*BYTE_W-1:2*BYTE_W];
  assign rsp.green_out = out_rgb[2*BYTE_W-1:BYTE_W];
  assign rsp.blue_out  = out_rgb[BYTE_W-1:0];

  // shared divider for the three channel increments
  gpb_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (steps),
    .done     (div_done),
    .quotient (div_quo)
  );

  // colour table
  gpb_table u_tbl (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .rd_en   (rd_en),
    .rd_addr (ridx_ext[TBL_AW-1:0]),
    .rd_data (tbl_rd_data)
  );

endmodule

// ===== design/gpb_checker.sv =====
// ----------------------------------------------------------------------------
// gpb_checker
// port-level checks on the gradient palette builder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpb_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_func,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_red,
  input logic [7:0] rsp_green,
  input logic [7:0] rsp_blue
);
  import gpb_pkg::*;

  logic        rd_beat;
  logic        rsp_stall;
  logic [23:0] rsp_rgb;

  assign rd_beat   = req_valid && req_ready && (req_func == FUNC_READ);
  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_rgb   = {rsp_red, rsp_green, rsp_blue};

  // no beat pending on rsp after reset
  `GPB_ASSERT(a_rst_no_rsp, clk, rst |=> !rsp_valid, "rsp valid after reset")

  // a read holds the block busy while the table is read
  `GPB_ASSERT_RST(a_read_busy, clk, rst, rd_beat |=> !req_ready, "ready right after read beat")

  // stalled response stays
  `GPB_ASSERT_RST(a_rsp_hold, clk, rst, rsp_stall |=> rsp_valid, "rsp valid dropped in stall")

  `GPB_ASSERT_RST(a_rsp_stable, clk, rst, rsp_stall |=> $stable(rsp_rgb), "rsp payload moved")

endmodule

bind gradient_palette_builder_top gpb_checker u_gpb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_func  (req.func),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_red   (rsp.red_out),
  .rsp_green (rsp.green_out),
  .rsp_blue  (rsp.blue_out)
);
